// ===== hdl/mwas_pkg.sv =====
package mwas_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_SIZE_DEFAULT    = 32;
   localparam int WEIGHT_BITS_DEFAULT = 16;

   // Configuration port layout.
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BIT  = 2;
   localparam int SIZE_REG_BITS  = 6;
   localparam logic REG_SIZE_IN_USE = 1'b0;
   localparam logic [SIZE_REG_BITS-1:0] SIZE_RESET = 6'd32;

   // Commands broadcast from the controller to the column cells.
   typedef logic [2:0] cell_op_type;
   localparam cell_op_type OP_CLEAR      = 3'd0;
   localparam cell_op_type OP_TREE_START = 3'd1;
   localparam cell_op_type OP_WAVE       = 3'd2;
   localparam cell_op_type OP_ADJUST     = 3'd3;
   localparam cell_op_type OP_JOIN       = 3'd4;
   localparam cell_op_type OP_PAIR       = 3'd5;

   typedef struct packed {
      logic        valid;
      cell_op_type op;
   } cell_ctrl_type;

endpackage

// ===== hdl/mwas_ram.sv =====
module mwas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mwas_cell.sv =====
module mwas_cell import mwas_pkg::*; #(
   parameter int MAX_SIZE    = MAX_SIZE_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
   parameter int CELL_INDEX  = 0,
   localparam int IDX_BITS   = $clog2(MAX_SIZE),
   localparam int CNT_BITS   = $clog2(MAX_SIZE + 1),
   localparam int LABEL_BITS = WEIGHT_BITS + CNT_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic [IDX_BITS-1:0]          sel,
   input  logic [CNT_BITS-1:0]          row,
   input  logic signed [LABEL_BITS-1:0] value,
   input  logic [WEIGHT_BITS-1:0]       weight,
   input  logic signed [LABEL_BITS-1:0] tok_best_in,
   input  logic [IDX_BITS-1:0]          tok_col_in,
   input  logic                         tok_found_in,
   output logic signed [LABEL_BITS-1:0] tok_best_out,
   output logic [IDX_BITS-1:0]          tok_col_out,
   output logic                         tok_found_out,
   output logic [CNT_BITS-1:0]          partner_out,
   output logic [CNT_BITS-1:0]          source_out
);

   localparam logic signed [LABEL_BITS-1:0] SLACK_NONE = {1'b0, {(LABEL_BITS-1){1'b1}}};
   localparam logic [CNT_BITS-1:0] FREE = CNT_BITS'(MAX_SIZE);

   logic signed [LABEL_BITS-1:0] label_ff, label_in;
   logic signed [LABEL_BITS-1:0] slack_ff, slack_in;
   logic [CNT_BITS-1:0]          source_ff, source_in;
   logic [CNT_BITS-1:0]          partner_ff, partner_in;
   logic                         in_tree_ff, in_tree_in;
   logic signed [LABEL_BITS-1:0] tok_best_ff, tok_best_in_next;
   logic [IDX_BITS-1:0]          tok_col_ff, tok_col_in_next;
   logic                         tok_found_ff, tok_found_in_next;

   logic                         here;
   logic [LABEL_BITS:0]          sum;
   logic signed [LABEL_BITS-1:0] cand;
   logic                         scan_hit;
   logic                         take;
   logic signed [LABEL_BITS-1:0] new_slack;
   logic                         wins;

   // Slack of this column against the row being scanned.
   always_comb begin
      here     = (sel == IDX_BITS'(CELL_INDEX));
      sum      = {value[LABEL_BITS-1], value} + {label_ff[LABEL_BITS-1], label_ff}
                 - {{(LABEL_BITS+1-WEIGHT_BITS){1'b0}}, weight};
      cand     = sum[LABEL_BITS-1:0];
      scan_hit = ctrl.valid && (ctrl.op == OP_WAVE) && here && !in_tree_ff;
      take     = scan_hit && (slack_ff > cand);
      new_slack = take ? cand : slack_ff;
      wins     = scan_hit && (new_slack < tok_best_in);
   end

   // Command decode for the column state.
   always_comb begin
      label_in   = label_ff;
      slack_in   = slack_ff;
      source_in  = source_ff;
      partner_in = partner_ff;
      in_tree_in = in_tree_ff;
      if (ctrl.valid) begin
         case (ctrl.op)
            OP_CLEAR: begin
               partner_in = FREE;
               label_in   = '0;
            end
            OP_TREE_START: begin
               in_tree_in = 1'b0;
               slack_in   = SLACK_NONE;
               source_in  = FREE;
            end
            OP_WAVE: begin
               if (take) begin
                  slack_in  = cand;
                  source_in = row;
               end
            end
            OP_ADJUST: begin
               if (in_tree_ff) begin
                  label_in = label_ff + value;
               end else if (slack_ff != SLACK_NONE) begin
                  slack_in = slack_ff - value;
               end
            end
            OP_JOIN: begin
               if (here) begin
                  in_tree_in = 1'b1;
               end
            end
            OP_PAIR: begin
               if (here) begin
                  partner_in = row;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The minimum-slack token moves one cell down the chain every cycle.
   always_comb begin
      if (wins) begin
         tok_best_in_next  = new_slack;
         tok_col_in_next   = IDX_BITS'(CELL_INDEX);
         tok_found_in_next = 1'b1;
      end else begin
         tok_best_in_next  = tok_best_in;
         tok_col_in_next   = tok_col_in;
         tok_found_in_next = tok_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partner_ff   <= FREE;
         in_tree_ff   <= 1'b0;
         tok_found_ff <= 1'b0;
      end else begin
         partner_ff   <= partner_in;
         in_tree_ff   <= in_tree_in;
         tok_found_ff <= tok_found_in_next;
      end
      label_ff    <= label_in;
      slack_ff    <= slack_in;
      source_ff   <= source_in;
      tok_best_ff <= tok_best_in_next;
      tok_col_ff  <= tok_col_in_next;
   end

   assign tok_best_out  = tok_best_ff;
   assign tok_col_out   = tok_col_ff;
   assign tok_found_out = tok_found_ff;
   assign partner_out   = partner_ff;
   assign source_out    = source_ff;

endmodule

// ===== hdl/max_weight_assignment_solver_core.sv =====
// Loading: one request per cycle, n*n requests for an n-by-n matrix.
// Solving: a greedy start pairs each row with its first row maximum if that column is free,
// then each tree step scans one row through the column-cell chain.
// Results: one per row, each held until the consumer takes it.
// A new matrix is accepted only after the last result has been taken.
// Synchronous active-high reset: size 32, load position zero, no result pending.
module max_weight_assignment_solver_core import mwas_pkg::*; #(
   parameter int MAX_SIZE    = MAX_SIZE_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
   localparam int IDX_BITS   = $clog2(MAX_SIZE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [WEIGHT_BITS-1:0]   req_weight,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_BITS-1:0]      rsp_row_index,
   output logic [IDX_BITS-1:0]      rsp_column_index,
   output logic [WEIGHT_BITS-1:0]   rsp_assigned_weight,
   output logic                     rsp_last_row,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CNT_BITS   = $clog2(MAX_SIZE + 1);
   localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int POS_BITS   = $clog2(DEPTH + 1);
   localparam int LABEL_BITS = WEIGHT_BITS + CNT_BITS + 1;
   localparam logic [CNT_BITS-1:0] FREE = CNT_BITS'(MAX_SIZE);
   localparam logic signed [LABEL_BITS-1:0] SLACK_NONE = {1'b0, {(LABEL_BITS-1){1'b1}}};

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_GREEDY = 4'd2;
   localparam logic [3:0] ST_GSET   = 4'd3;
   localparam logic [3:0] ST_SEARCH = 4'd4;
   localparam logic [3:0] ST_TSTART = 4'd5;
   localparam logic [3:0] ST_POP    = 4'd6;
   localparam logic [3:0] ST_WAVE   = 4'd7;
   localparam logic [3:0] ST_ADJ    = 4'd8;
   localparam logic [3:0] ST_CHECK  = 4'd9;
   localparam logic [3:0] ST_FLIP   = 4'd10;
   localparam logic [3:0] ST_ORD    = 4'd11;
   localparam logic [3:0] ST_OLAT   = 4'd12;
   localparam logic [3:0] ST_OWAIT  = 4'd13;

   logic [3:0]               state_ff, state_in;
   logic [SIZE_REG_BITS-1:0] size_ff, size_in;
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [POS_BITS-1:0]      base_ff, base_in;
   logic [CNT_BITS-1:0]      k_ff, k_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]      rd_tag_ff, rd_tag_in;
   logic [CNT_BITS-1:0]      row_ff, row_in;
   logic [WEIGHT_BITS-1:0]   gmax_ff, gmax_in;
   logic [IDX_BITS-1:0]      gbest_ff, gbest_in;
   logic [CNT_BITS-1:0]      match_ff, match_in;
   logic [CNT_BITS-1:0]      scan_ff, scan_in;
   logic [CNT_BITS-1:0]      qh_ff, qh_in;
   logic [CNT_BITS-1:0]      qt_ff, qt_in;
   logic [IDX_BITS-1:0]      x_ff, x_in;
   logic [IDX_BITS-1:0]      y_ff, y_in;
   logic [IDX_BITS-1:0]      fx_ff, fx_in;
   logic [IDX_BITS-1:0]      fy_ff, fy_in;
   logic [IDX_BITS-1:0]      ocol_ff, ocol_in;
   logic                     ook_ff, ook_in;
   logic signed [LABEL_BITS-1:0] rl_ff [MAX_SIZE];
   logic signed [LABEL_BITS-1:0] rl_in [MAX_SIZE];
   logic [CNT_BITS-1:0]      rp_ff [MAX_SIZE];
   logic [CNT_BITS-1:0]      rp_in [MAX_SIZE];
   logic [MAX_SIZE-1:0]      rin_ff, rin_in;
   logic [IDX_BITS-1:0]      queue_ff [MAX_SIZE];
   logic [IDX_BITS-1:0]      queue_in [MAX_SIZE];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]      rsp_row_ff, rsp_row_in;
   logic [IDX_BITS-1:0]      rsp_col_ff, rsp_col_in;
   logic [WEIGHT_BITS-1:0]   rsp_weight_ff, rsp_weight_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [CNT_BITS-1:0]      n;
   logic [CNT_BITS-1:0]      n_m1;
   logic [POS_BITS-1:0]      total;
   logic                     csr_write;

   logic                     ram_we;
   logic [ADDR_BITS-1:0]     ram_raddr;
   logic [WEIGHT_BITS-1:0]   ram_rdata;

   cell_ctrl_type                cctl;
   logic [IDX_BITS-1:0]          csel;
   logic [CNT_BITS-1:0]          crow;
   logic signed [LABEL_BITS-1:0] cval;
   logic [WEIGHT_BITS-1:0]       cweight;

   logic signed [LABEL_BITS-1:0] tok_best [MAX_SIZE+1];
   logic [IDX_BITS-1:0]          tok_col [MAX_SIZE+1];
   logic                         tok_found [MAX_SIZE+1];
   logic [CNT_BITS-1:0]          cpart [MAX_SIZE];
   logic [CNT_BITS-1:0]          csrc [MAX_SIZE];

   logic [IDX_BITS-1:0]      rp_addr;
   logic [CNT_BITS-1:0]      rp_rd;
   logic [IDX_BITS-1:0]      col_sel;
   logic [CNT_BITS-1:0]      cp_sel;
   logic [CNT_BITS-1:0]      src_sel;

   // Effective matrix size: zero counts as one, large values saturate.
   always_comb begin
      if (size_ff == '0) begin
         n = CNT_BITS'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         n = CNT_BITS'(MAX_SIZE);
      end else begin
         n = CNT_BITS'(size_ff);
      end
      n_m1  = n - CNT_BITS'(1);
      total = POS_BITS'(n) * POS_BITS'(n);
   end

   // Configuration port.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_INDEX_BIT] == REG_SIZE_IN_USE) ?
                       CSR_DATA_BITS'(size_ff) : '0;

   // Matrix store.
   mwas_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff[ADDR_BITS-1:0]),
      .wr_data (req_weight),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Column cells; the slack token enters the first cell empty.
   assign tok_best[0]  = SLACK_NONE;
   assign tok_col[0]   = '0;
   assign tok_found[0] = 1'b0;

   for (genvar c = 0; c < MAX_SIZE; c++) begin : g_cell
      mwas_cell #(
         .MAX_SIZE    (MAX_SIZE),
         .WEIGHT_BITS (WEIGHT_BITS),
         .CELL_INDEX  (c)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cctl),
         .sel           (csel),
         .row           (crow),
         .value         (cval),
         .weight        (cweight),
         .tok_best_in   (tok_best[c]),
         .tok_col_in    (tok_col[c]),
         .tok_found_in  (tok_found[c]),
         .tok_best_out  (tok_best[c+1]),
         .tok_col_out   (tok_col[c+1]),
         .tok_found_out (tok_found[c+1]),
         .partner_out   (cpart[c]),
         .source_out    (csrc[c])
      );
   end

   // Single read address into the row partners.
   always_comb begin
      case (state_ff)
         ST_FLIP: rp_addr = fx_ff;
         ST_ORD:  rp_addr = row_ff[IDX_BITS-1:0];
         default: rp_addr = scan_ff[IDX_BITS-1:0];
      endcase
      rp_rd = rp_ff[rp_addr];
   end

   // Single read address into the column cells.
   always_comb begin
      case (state_ff)
         ST_CHECK: col_sel = y_ff;
         ST_FLIP:  col_sel = rp_rd[IDX_BITS-1:0];
         default:  col_sel = gbest_ff;
      endcase
      cp_sel  = cpart[col_sel];
      src_sel = csrc[col_sel];
   end

   assign req_ready = (state_ff == ST_LOAD);

   // Sequencer.
   always_comb begin
      logic [POS_BITS-1:0] stream_addr;
      logic [POS_BITS-1:0] out_addr;

      state_in      = state_ff;
      size_in       = size_ff;
      pos_in        = pos_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      rd_valid_in   = 1'b0;
      rd_tag_in     = rd_tag_ff;
      row_in        = row_ff;
      gmax_in       = gmax_ff;
      gbest_in      = gbest_ff;
      match_in      = match_ff;
      scan_in       = scan_ff;
      qh_in         = qh_ff;
      qt_in         = qt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      ocol_in       = ocol_ff;
      ook_in        = ook_ff;
      rl_in         = rl_ff;
      rp_in         = rp_ff;
      rin_in        = rin_ff;
      queue_in      = queue_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_raddr     = '0;
      cctl          = '{valid: 1'b0, op: OP_CLEAR};
      csel          = '0;
      crow          = '0;
      cval          = '0;
      cweight       = ram_rdata;
      stream_addr   = base_ff + POS_BITS'(k_ff);
      out_addr      = base_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               ram_we = 1'b1;
               if (pos_ff == total - POS_BITS'(1)) begin
                  pos_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
               end
            end
         end
         ST_CLEAR: begin
            cctl     = '{valid: 1'b1, op: OP_CLEAR};
            for (int i = 0; i < MAX_SIZE; i++) begin
               rp_in[i] = FREE;
            end
            match_in = '0;
            row_in   = '0;
            base_in  = '0;
            k_in     = '0;
            state_in = ST_GREEDY;
         end
         ST_GREEDY: begin
            if (k_ff < n) begin
               ram_raddr   = stream_addr[ADDR_BITS-1:0];
               rd_valid_in = 1'b1;
               rd_tag_in   = k_ff[IDX_BITS-1:0];
               k_in        = k_ff + CNT_BITS'(1);
            end
            // First maximum of the row wins.
            if (rd_valid_ff) begin
               if (rd_tag_ff == '0 || ram_rdata > gmax_ff) begin
                  gmax_in  = ram_rdata;
                  gbest_in = rd_tag_ff;
               end
               if (CNT_BITS'(rd_tag_ff) == n_m1) begin
                  state_in = ST_GSET;
               end
            end
         end
         ST_GSET: begin
            rl_in[row_ff[IDX_BITS-1:0]] = LABEL_BITS'(gmax_ff);
            if (cp_sel == FREE) begin
               rp_in[row_ff[IDX_BITS-1:0]] = CNT_BITS'(gbest_ff);
               cctl     = '{valid: 1'b1, op: OP_PAIR};
               csel     = gbest_ff;
               crow     = row_ff;
               match_in = match_ff + CNT_BITS'(1);
            end
            row_in  = row_ff + CNT_BITS'(1);
            base_in = base_ff + POS_BITS'(n);
            k_in    = '0;
            if (row_ff == n_m1) begin
               scan_in  = '0;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_GREEDY;
            end
         end
         ST_SEARCH: begin
            // Matched rows stay matched, so the lowest free row only moves up.
            if (match_ff == n || scan_ff == n) begin
               row_in   = '0;
               base_in  = '0;
               state_in = ST_ORD;
            end else if (rp_rd == FREE) begin
               state_in = ST_TSTART;
            end else begin
               scan_in = scan_ff + CNT_BITS'(1);
            end
         end
         ST_TSTART: begin
            cctl   = '{valid: 1'b1, op: OP_TREE_START};
            rin_in = '0;
            rin_in[scan_ff[IDX_BITS-1:0]] = 1'b1;
            queue_in[0] = scan_ff[IDX_BITS-1:0];
            qh_in    = '0;
            qt_in    = CNT_BITS'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            x_in     = queue_ff[qh_ff[IDX_BITS-1:0]];
            qh_in    = qh_ff + CNT_BITS'(1);
            base_in  = POS_BITS'(queue_ff[qh_ff[IDX_BITS-1:0]]) * POS_BITS'(n);
            k_in     = '0;
            state_in = ST_WAVE;
         end
         ST_WAVE: begin
            if (k_ff < n) begin
               ram_raddr   = stream_addr[ADDR_BITS-1:0];
               rd_valid_in = 1'b1;
               rd_tag_in   = k_ff[IDX_BITS-1:0];
               k_in        = k_ff + CNT_BITS'(1);
            end
            // Each weight meets its column cell together with the token.
            if (rd_valid_ff) begin
               cctl    = '{valid: 1'b1, op: OP_WAVE};
               csel    = rd_tag_ff;
               crow    = CNT_BITS'(x_ff);
               cval    = rl_ff[x_ff];
               cweight = ram_rdata;
               if (CNT_BITS'(rd_tag_ff) == n_m1) begin
                  state_in = ST_ADJ;
               end
            end
         end
         ST_ADJ: begin
            if (!tok_found[n]) begin
               row_in   = '0;
               base_in  = '0;
               state_in = ST_ORD;
            end else begin
               cctl = '{valid: 1'b1, op: OP_ADJUST};
               cval = tok_best[n];
               for (int i = 0; i < MAX_SIZE; i++) begin
                  if (rin_ff[i]) begin
                     rl_in[i] = rl_ff[i] - tok_best[n];
                  end
               end
               y_in     = tok_col[n];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cp_sel == FREE) begin
               fy_in    = y_ff;
               fx_in    = src_sel[IDX_BITS-1:0];
               state_in = ST_FLIP;
            end else begin
               cctl = '{valid: 1'b1, op: OP_JOIN};
               csel = y_ff;
               rin_in[cp_sel[IDX_BITS-1:0]]   = 1'b1;
               queue_in[qt_ff[IDX_BITS-1:0]] = cp_sel[IDX_BITS-1:0];
               qt_in    = qt_ff + CNT_BITS'(1);
               state_in = ST_POP;
            end
         end
         ST_FLIP: begin
            // One edge of the augmenting path is flipped per cycle.
            rp_in[fx_ff] = CNT_BITS'(fy_ff);
            cctl = '{valid: 1'b1, op: OP_PAIR};
            csel = fy_ff;
            crow = CNT_BITS'(fx_ff);
            if (rp_rd == FREE) begin
               match_in = match_ff + CNT_BITS'(1);
               state_in = ST_SEARCH;
            end else begin
               fy_in = rp_rd[IDX_BITS-1:0];
               fx_in = src_sel[IDX_BITS-1:0];
            end
         end
         ST_ORD: begin
            if (rp_rd < n) begin
               ocol_in  = rp_rd[IDX_BITS-1:0];
               ook_in   = 1'b1;
               out_addr = base_ff + POS_BITS'(rp_rd);
            end else begin
               ocol_in = '0;
               ook_in  = 1'b0;
            end
            ram_raddr = out_addr[ADDR_BITS-1:0];
            state_in  = ST_OLAT;
         end
         ST_OLAT: begin
            rsp_valid_in  = 1'b1;
            rsp_row_in    = row_ff[IDX_BITS-1:0];
            rsp_col_in    = ocol_ff;
            rsp_weight_in = ook_ff ? ram_rdata : '0;
            rsp_last_in   = (row_ff == n_m1);
            state_in      = ST_OWAIT;
         end
         ST_OWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  row_in   = row_ff + CNT_BITS'(1);
                  base_in  = base_ff + POS_BITS'(n);
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // A size write restarts the matrix load.
      if (csr_write && csr_pready && csr_paddr[CSR_INDEX_BIT] == REG_SIZE_IN_USE) begin
         size_in = csr_pwdata[SIZE_REG_BITS-1:0];
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= SIZE_RESET;
         pos_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pos_ff       <= pos_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      k_ff          <= k_in;
      rd_tag_ff     <= rd_tag_in;
      row_ff        <= row_in;
      gmax_ff       <= gmax_in;
      gbest_ff      <= gbest_in;
      match_ff      <= match_in;
      scan_ff       <= scan_in;
      qh_ff         <= qh_in;
      qt_ff         <= qt_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      fx_ff         <= fx_in;
      fy_ff         <= fy_in;
      ocol_ff       <= ocol_in;
      ook_ff        <= ook_in;
      rl_ff         <= rl_in;
      rp_ff         <= rp_in;
      rin_ff        <= rin_in;
      queue_ff      <= queue_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_row_index       = rsp_row_ff;
   assign rsp_column_index    = rsp_col_ff;
   assign rsp_assigned_weight = rsp_weight_ff;
   assign rsp_last_row        = rsp_last_ff;

endmodule

// ===== hdl/mwas_checker.sv =====
module mwas_checker import mwas_pkg::*; #(
   parameter int MAX_SIZE    = MAX_SIZE_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
   localparam int IDX_BITS   = $clog2(MAX_SIZE)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [IDX_BITS-1:0]      rsp_row_index,
   input logic [IDX_BITS-1:0]      rsp_column_index,
   input logic [WEIGHT_BITS-1:0]   rsp_assigned_weight,
   input logic                     rsp_last_row
);

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_column_index) && $stable(rsp_assigned_weight)
         && $stable(rsp_last_row))
      else $error("result changed while stalled");

   // Loading and reporting never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // Each taken result is followed by a cycle without one.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result presented back to back");

   // More rows to report keep the request side closed.
   a_rows_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=> !req_ready)
      else $error("request side opened before the last row");

endmodule

bind max_weight_assignment_solver_core mwas_checker #(
   .MAX_SIZE    (MAX_SIZE),
   .WEIGHT_BITS (WEIGHT_BITS)
) u_mwas_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mwas_pkg::*;

   localparam int N_MAX      = MAX_SIZE_DEFAULT;
   localparam int WB         = WEIGHT_BITS_DEFAULT;
   localparam longint NO_SLK = 64'sh7fff_ffff_ffff_ffff;
   localparam int FREE       = N_MAX;
   localparam int IDLE_WAIT  = 8;

   typedef enum logic {STIM_SIZE, STIM_WEIGHT} stim_kind_type;

   typedef struct {
      stim_kind_type kind;
      logic [15:0]   value;
      bit            typed;
      logic [4:0]    col;
      logic [15:0]   wt;
   } stim_row_type;

   typedef struct {
      logic [4:0]    row;
      logic [4:0]    col;
      logic [WB-1:0] wt;
      logic          last;
   } assign_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [WB-1:0]            req_weight = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [4:0]               rsp_row_index;
   logic [4:0]               rsp_column_index;
   logic [WB-1:0]            rsp_assigned_weight;
   logic                     rsp_last_row;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   max_weight_assignment_solver_core dut (.*);

   always #5 clock = ~clock;

   // Shadow state of the solver.
   logic [5:0]    size_reg;
   int            load_pos;
   logic [WB-1:0] weights [N_MAX*N_MAX];
   longint        row_lab [N_MAX];
   longint        col_lab [N_MAX];
   longint        col_slk [N_MAX];
   int            row_mate [N_MAX];
   int            col_mate [N_MAX];
   int            slk_src [N_MAX];
   bit            col_tree [N_MAX];
   bit            row_tree [N_MAX];
   int            matched;

   assign_type assign_q[$];
   int      errors = 0;
   int      results_seen = 0;
   bit      sender_burst = 0;
   bit      taker_burst = 0;

   function automatic longint wt_at(int n, int r, int c);
      return longint'(weights[r*n + c]);
   endfunction

   // One alternating-tree phase from a free root, then the path flip.
   function automatic void grow_tree(int n, int root);
      int qh, qt, i, y, x, guard, prev;
      int tq [N_MAX];
      longint best, d, s;
      qh = 0;
      qt = 0;
      y = 0;
      for (i = 0; i < n; i++) begin
         col_tree[i] = 0;
         row_tree[i] = 0;
         col_slk[i] = NO_SLK;
         slk_src[i] = FREE;
      end
      tq[qt] = root;
      qt++;
      row_tree[root] = 1;
      while (qh < qt) begin
         best = NO_SLK;
         x = tq[qh];
         qh++;
         for (i = 0; i < n; i++) begin
            s = row_lab[x] + col_lab[i] - wt_at(n, x, i);
            if (!col_tree[i] && col_slk[i] > s) begin
               col_slk[i] = s;
               slk_src[i] = x;
            end
         end
         y = -1;
         for (i = 0; i < n; i++) begin
            if (!col_tree[i] && col_slk[i] < best) begin
               best = col_slk[i];
               y = i;
            end
         end
         if (y < 0) return;
         d = best;
         for (i = 0; i < n; i++) begin
            if (row_tree[i]) row_lab[i] -= d;
            if (col_tree[i]) col_lab[i] += d;
            else if (col_slk[i] != NO_SLK) col_slk[i] -= d;
         end
         if (col_mate[y] == FREE) break;
         col_tree[y] = 1;
         x = col_mate[y];
         if (x < 0 || x >= n || qt >= N_MAX) return;
         row_tree[x] = 1;
         tq[qt] = x;
         qt++;
      end
      x = slk_src[y];
      for (guard = 0; guard <= n; guard++) begin
         if (x < 0 || x >= n) return;
         prev = row_mate[x];
         row_mate[x] = y;
         col_mate[y] = x;
         if (prev == FREE || prev < 0 || prev >= n) break;
         y = prev;
         x = slk_src[y];
      end
      matched++;
   endfunction

   // Accepts one weight; on the final entry solves and fills the assignment list.
   function automatic void predict_weight(logic [WB-1:0] w, ref assign_type outs[$]);
      int n, total, i, j, pick, root, prior;
      longint m;
      assign_type a;
      n = (size_reg == 0) ? 1 : (size_reg > N_MAX) ? N_MAX : int'(size_reg);
      total = n * n;
      outs.delete();
      if (load_pos >= total) load_pos = 0;
      weights[load_pos] = w;
      load_pos++;
      if (load_pos < total) return;
      load_pos = 0;

      // Greedy start on the first row maximum.
      matched = 0;
      for (i = 0; i < N_MAX; i++) begin
         row_mate[i] = FREE;
         col_mate[i] = FREE;
         col_lab[i] = 0;
      end
      for (i = 0; i < n; i++) begin
         pick = 0;
         m = wt_at(n, i, 0);
         for (j = 1; j < n; j++) begin
            if (wt_at(n, i, j) > m) begin
               m = wt_at(n, i, j);
               pick = j;
            end
         end
         row_lab[i] = m;
         if (col_mate[pick] == FREE) begin
            row_mate[i] = pick;
            col_mate[pick] = i;
            matched++;
         end
      end
      while (matched < n) begin
         root = -1;
         prior = matched;
         for (i = 0; i < n; i++) begin
            if (row_mate[i] == FREE) begin
               root = i;
               break;
            end
         end
         if (root < 0) break;
         grow_tree(n, root);
         if (matched == prior) break;
      end

      for (i = 0; i < n; i++) begin
         a.row = i[4:0];
         a.last = (i == n - 1);
         if (row_mate[i] < 0 || row_mate[i] >= n) begin
            a.col = '0;
            a.wt = '0;
         end else begin
            a.col = row_mate[i][4:0];
            a.wt = weights[i*n + row_mate[i]];
         end
         outs.push_back(a);
      end
   endfunction

   // Offer one weight request and hold it until the block takes it.
   task automatic send_weight(logic [WB-1:0] w, ref assign_type outs[$]);
      int gap;
      if ($urandom_range(0, 29) == 0) sender_burst = ~sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_weight <= w;
      do @(posedge clock); while (!req_ready);
      predict_weight(w, outs);
   endtask

   // Let every pending result drain before touching the register.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (assign_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_size(logic [5:0] v);
      drain_results();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_SIZE_IN_USE, 2'b00};
      csr_pwdata <= CSR_DATA_BITS'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      size_reg = v;
      load_pos = 0;
   endtask

   task automatic read_size(logic [5:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {REG_SIZE_IN_USE, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[5:0] !== want) begin
         $display("%0t: size register read expected %0d actual %0d", $time, want,
                  csr_prdata[5:0]);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [WB-1:0] random_weight(int mode);
      case (mode)
         0: return WB'($urandom_range(0, 3));
         1: return $urandom_range(0, 1) ? '1 : '0;
         default: return WB'($urandom());
      endcase
   endfunction

   // Directed stimulus: single-entry matrices, ties, greedy conflicts, reload.
   stim_row_type directed [] = '{
      '{STIM_SIZE,   16'd0,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd0,     1, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'hffff,  1, 5'd0, 16'hffff},
      '{STIM_SIZE,   16'd1,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'h8001,  1, 5'd0, 16'h8001},
      '{STIM_SIZE,   16'd2,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd5,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd5,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd5,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd5,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'hffff,  0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'hffff,  0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'hffff,  0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd0,     0, 5'd0, 16'd0},
      '{STIM_SIZE,   16'd3,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd77,    0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd78,    0, 5'd0, 16'd0},
      '{STIM_SIZE,   16'd3,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd9,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd1,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd2,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd9,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd3,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd1,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd9,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd2,     0, 5'd0, 16'd0},
      '{STIM_WEIGHT, 16'd3,     0, 5'd0, 16'd0}
   };

   // Request side.
   initial begin
      assign_type outs[$];
      assign_type a;
      int sent, mats, mode, n, k, i;
      logic [5:0] sz;
      size_reg = SIZE_RESET;
      load_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_size(SIZE_RESET);

      foreach (directed[r]) begin
         if (directed[r].kind == STIM_SIZE) begin
            write_size(directed[r].value[5:0]);
         end else begin
            send_weight(directed[r].value, outs);
            if (directed[r].typed && outs.size() != 0) begin
               a = '{5'd0, directed[r].col, directed[r].wt, 1'b1};
               assign_q.push_back(a);
            end else begin
               foreach (outs[j]) assign_q.push_back(outs[j]);
            end
         end
      end

      // Random matrices of small sizes, a few per setting.
      sent = 0;
      while (sent < 430) begin
         sz = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 7));
         write_size(sz);
         n = (sz == 0) ? 1 : int'(sz);
         mats = $urandom_range(1, 4);
         for (k = 0; k < mats && sent < 430; k++) begin
            mode = $urandom_range(0, 2);
            for (i = 0; i < n * n; i++) begin
               send_weight(random_weight(mode), outs);
               foreach (outs[j]) assign_q.push_back(outs[j]);
               sent++;
            end
         end
      end

      // An oversized setting reads back as written; a size write cuts its load short.
      write_size(6'd63);
      read_size(6'd63);
      for (i = 0; i < 20; i++) begin
         send_weight(random_weight(2), outs);
         foreach (outs[j]) assign_q.push_back(outs[j]);
      end
      write_size(6'd2);
      for (i = 0; i < 4; i++) begin
         send_weight(random_weight(2), outs);
         foreach (outs[j]) assign_q.push_back(outs[j]);
      end
      req_valid <= 1'b0;

      while (assign_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result side: random stalls, two long hold-offs, in-order field compare.
   initial begin
      assign_type e;
      int gap;
      forever begin
         if ($urandom_range(0, 29) == 0) taker_burst = ~taker_burst;
         gap = taker_burst ? 0 : $urandom_range(0, 16);
         if (results_seen == 20 || results_seen == 60) gap = 400;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_valid);
         results_seen++;
         if (assign_q.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d", $time, rsp_row_index,
                     rsp_column_index);
            errors++;
         end else begin
            e = assign_q.pop_front();
            if (rsp_row_index !== e.row) begin
               $display("%0t: row expected %0d actual %0d", $time, e.row, rsp_row_index);
               errors++;
            end
            if (rsp_column_index !== e.col) begin
               $display("%0t: column expected %0d actual %0d", $time, e.col,
                        rsp_column_index);
               errors++;
            end
            if (rsp_assigned_weight !== e.wt) begin
               $display("%0t: weight expected %0d actual %0d", $time, e.wt,
                        rsp_assigned_weight);
               errors++;
            end
            if (rsp_last_row !== e.last) begin
               $display("%0t: last expected %0b actual %0b", $time, e.last, rsp_last_row);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
